@@ hw/rtl/triangle_box_overlap_test_top_macros.svh @@
// Assertion macros for the triangle/box overlap test.
// Included by the top level; needs nothing else.
`ifndef TRIANGLE_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_TOP_MACROS_SVH

// same-cycle implication
`define TBO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TBO_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tbo_pkg.sv @@
// Shared types and constants for the triangle/box overlap test.
// No dependencies.
package tbo_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned MarginW = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [2:0][CoordW-1:0] point_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_LOW_X     = 3'd0,
    REG_BOX_LOW_Y     = 3'd1,
    REG_BOX_LOW_Z     = 3'd2,
    REG_BOX_HIGH_X    = 3'd3,
    REG_BOX_HIGH_Y    = 3'd4,
    REG_BOX_HIGH_Z    = 3'd5,
    REG_VERTEX_MARGIN = 3'd6
  } cfg_reg_t;

  localparam logic [MarginW-1:0] MarginReset = 16'd7;

  // vertex within the box widened by the margin, inclusive bounds
  function automatic logic vertex_inside(point_t v, point_t lo, point_t hi,
                                         logic [MarginW-1:0] m);
    logic signed [33:0] vv;
    logic signed [33:0] lw;
    logic signed [33:0] hg;
    logic signed [33:0] mm;
    logic ok;
    ok = 1'b1;
    mm = $signed({18'd0, m});
    for (int k = 0; k < 3; k++) begin
      vv = $signed({{2{v[k][31]}}, v[k]});
      lw = $signed({{2{lo[k][31]}}, lo[k]}) - mm;
      hg = $signed({{2{hi[k][31]}}, hi[k]}) + mm;
      if (vv < lw || vv > hg) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ hw/rtl/tbo_if.sv @@
// Channel interfaces: triangle input, result output, register writes.
// Depends on nothing.
interface tbo_tri_if;
  logic valid;
  logic ready;
  logic signed [31:0] v0_x, v0_y, v0_z;
  logic signed [31:0] v1_x, v1_y, v1_z;
  logic signed [31:0] v2_x, v2_y, v2_z;
  modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, input ready);
  modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
               v2_x, v2_y, v2_z, output ready);
endinterface

interface tbo_res_if;
  logic valid;
  logic ready;
  logic overlaps;
  logic hit_by_vertex;
  modport source(output valid, overlaps, hit_by_vertex, input ready);
  modport sink(input valid, overlaps, hit_by_vertex, output ready);
endinterface

interface tbo_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/tbo_edge_clip.sv @@
// Three-stage slab clipper for one triangle edge a->b against the box.
// Depends on tbo_pkg.
module tbo_edge_clip
  import tbo_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  point_t    a,
  input  point_t    b,
  input  point_t    lo,
  input  point_t    hi,
  output logic      hit
);

  // stage 1: entering numerator, leaving numerator, |direction| per axis
  logic signed [32:0] en_c [3];
  logic signed [32:0] lv_c [3];
  logic        [31:0] ad_c [3];
  logic               zr_c [3];

  logic signed [32:0] en1 [3];
  logic signed [32:0] lv1 [3];
  logic        [31:0] ad1 [3];
  logic               zr1 [3];

  always_comb begin
    logic signed [32:0] sa, sb, slo, shi, d;
    logic pos;
    for (int k = 0; k < 3; k++) begin
      sa  = $signed({a[k][31], a[k]});
      sb  = $signed({b[k][31], b[k]});
      slo = $signed({lo[k][31], lo[k]});
      shi = $signed({hi[k][31], hi[k]});
      d   = sb - sa;
      pos = !d[32] && (d != '0);
      // moving up: enter at low slab, leave at high; else mirrored
      en_c[k] = pos ? slo - sa : sa - shi;
      lv_c[k] = pos ? shi - sa : sa - slo;
      ad_c[k] = pos ? d[31:0] : 32'(-d);
      zr_c[k] = (d == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      en1 <= en_c;
      lv1 <= lv_c;
      ad1 <= ad_c;
      zr1 <= zr_c;
    end
  end

  // stage 2: reject and active flags
  logic        rej_c;
  logic        ea_c [3];
  logic        la_c [3];
  logic        rej2;
  logic        ea2  [3];
  logic        la2  [3];
  logic [31:0] enm2 [3];
  logic [31:0] lvm2 [3];
  logic [31:0] ad2  [3];

  always_comb begin
    logic signed [32:0] ads;
    rej_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ads = $signed({1'b0, ad1[k]});
      if (zr1[k]) begin
        ea_c[k] = 1'b0;
        la_c[k] = 1'b0;
        if (en1[k] > 0 || lv1[k] < 0) rej_c = 1'b1;
      end else begin
        ea_c[k] = en1[k] > 0;
        la_c[k] = lv1[k] < ads;
        if (en1[k] > ads || lv1[k] < 0) rej_c = 1'b1;
        // same axis shares the denominator
        if (ea_c[k] && la_c[k] && en1[k] > lv1[k]) rej_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rej2 <= rej_c;
      ea2  <= ea_c;
      la2  <= la_c;
      for (int k = 0; k < 3; k++) begin
        enm2[k] <= en1[k][31:0];
        lvm2[k] <= lv1[k][31:0];
      end
      ad2 <= ad1;
    end
  end

  // stage 3: cross products, entering i against leaving j
  logic        rej3;
  logic        msk3 [3][3];
  logic [63:0] pl3  [3][3];
  logic [63:0] pr3  [3][3];

  always_ff @(posedge clk) begin
    if (en.s3) begin
      rej3 <= rej2;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (i == j) begin
            msk3[i][j] <= 1'b0;
            pl3[i][j]  <= '0;
            pr3[i][j]  <= '0;
          end else begin
            msk3[i][j] <= ea2[i] && la2[j];
            pl3[i][j]  <= enm2[i] * ad2[j];
            pr3[i][j]  <= lvm2[j] * ad2[i];
          end
        end
      end
    end
  end

  always_comb begin
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (msk3[i][j] && pl3[i][j] > pr3[i][j]) bad = 1'b1;
    hit = !rej3 && !bad;
  end

endmodule

@@ hw/rtl/triangle_box_overlap_test_top.sv @@
// Top level of the triangle/box overlap test: registers, pipeline control,
// vertex test. Depends on tbo_pkg, tbo_if, tbo_edge_clip and the macro header.
//
// Usage:
//  - tri_in carries one triangle per transaction (three Q16.16 vertices).
//  - res_out returns one transaction per triangle, in order: overlaps and
//    hit_by_vertex (the latter only set when a vertex sits in the box
//    widened by vertex_margin).
//  - cfg writes box corners (index 0..5) and vertex_margin (index 6); any
//    other index is dropped. cfg is always ready; write only when idle.
//  - One triangle per cycle sustained while res_out is ready. Four register
//    stages: differences, slab flags, 32x32 cross products, result register.
//  - A stalled res_out holds its result; earlier stages keep filling any
//    empty slots, so tri_in stays ready until every stage holds an item.
//  - Reset clears all stage valids, the box to zero and vertex_margin to 7.
`include "triangle_box_overlap_test_top_macros.svh"

module triangle_box_overlap_test_top
  import tbo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tbo_tri_if.sink   tri_in,
  tbo_res_if.source res_out,
  tbo_cfg_if.sink   cfg
);

  point_t             box_lo;
  point_t             box_hi;
  logic [MarginW-1:0] margin;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_lo <= '0;
      box_hi <= '0;
      margin <= MarginReset;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BOX_LOW_X:     box_lo[0] <= cfg.data;
        REG_BOX_LOW_Y:     box_lo[1] <= cfg.data;
        REG_BOX_LOW_Z:     box_lo[2] <= cfg.data;
        REG_BOX_HIGH_X:    box_hi[0] <= cfg.data;
        REG_BOX_HIGH_Y:    box_hi[1] <= cfg.data;
        REG_BOX_HIGH_Z:    box_hi[2] <= cfg.data;
        REG_VERTEX_MARGIN: margin    <= cfg.data[MarginW-1:0];
        default: ;
      endcase
    end
  end

  point_t p0, p1, p2;
  assign p0 = {tri_in.v0_z, tri_in.v0_y, tri_in.v0_x};
  assign p1 = {tri_in.v1_z, tri_in.v1_y, tri_in.v1_x};
  assign p2 = {tri_in.v2_z, tri_in.v2_y, tri_in.v2_x};

  // stall control, bubbles collapse
  logic v1, v2, v3, v4;
  logic e1, e2, e3, e4;
  stage_en_t sen;

  assign e4 = !v4 || res_out.ready;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign tri_in.ready = e1;
  assign sen = '{s1: e1, s2: e2, s3: e3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (e1) v1 <= tri_in.valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
    end
  end

  logic vh1, vh2, vh3;
  always_ff @(posedge clk) begin
    if (e1) vh1 <= vertex_inside(p0, box_lo, box_hi, margin) ||
                   vertex_inside(p1, box_lo, box_hi, margin) ||
                   vertex_inside(p2, box_lo, box_hi, margin);
    if (e2) vh2 <= vh1;
    if (e3) vh3 <= vh2;
  end

  logic [2:0] ehit;

  tbo_edge_clip u_edge0 (.clk(clk), .en(sen), .a(p0), .b(p1),
                         .lo(box_lo), .hi(box_hi), .hit(ehit[0]));
  tbo_edge_clip u_edge1 (.clk(clk), .en(sen), .a(p1), .b(p2),
                         .lo(box_lo), .hi(box_hi), .hit(ehit[1]));
  tbo_edge_clip u_edge2 (.clk(clk), .en(sen), .a(p2), .b(p0),
                         .lo(box_lo), .hi(box_hi), .hit(ehit[2]));

  logic ovl4, hbv4;
  always_ff @(posedge clk) begin
    if (e4) begin
      ovl4 <= vh3 || (|ehit);
      hbv4 <= vh3;
    end
  end

  assign res_out.valid         = v4;
  assign res_out.overlaps      = ovl4;
  assign res_out.hit_by_vertex = hbv4;

  `TBO_ASSERT_IMP(a_vertex_implies_overlap, clk, rst, v4, !hbv4 || ovl4, "vertex hit without overlap")
  `TBO_ASSERT_NXT(a_accept_fills_s1, clk, rst, tri_in.valid && tri_in.ready, v1, "accepted triangle lost")
  `TBO_ASSERT_IMP(a_ready_only_when_full, clk, rst, !tri_in.ready, v1 && v2 && v3 && v4, "stall with a free stage")
  `TBO_ASSERT_NXT(a_margin_write, clk, rst, cfg.valid && cfg.index == REG_VERTEX_MARGIN, margin == $past(cfg.data[MarginW-1:0]), "margin write lost")

endmodule

@@ tb/tb_triangle_box_overlap_test_top.sv @@
// Testbench for the triangle/box overlap test: drives triangles, box settings and
// result back-pressure, and checks every result against a built-in predictor.
// Depends on tbo_pkg, tbo_if and the top level.
class overlap_scoreboard;
  bit exp_overlap[$];
  bit exp_vertex[$];
  int mismatches;
  int checked;
  int hits;
  int vertex_hits;

  function void note_triangle(bit ov, bit bv);
    exp_overlap = {exp_overlap, ov};
    exp_vertex = {exp_vertex, bv};
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endfunction

  function void check_result(bit ov, bit bv);
    bit eo;
    bit ev;
    if (exp_overlap.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    eo = exp_overlap.pop_front();
    ev = exp_vertex.pop_front();
    checked++;
    if (eo) hits++;
    if (ev) vertex_hits++;
    if (ov !== eo) report($sformatf("overlaps got %0b want %0b (result %0d)", ov, eo, checked));
    if (bv !== ev)
      report($sformatf("hit_by_vertex got %0b want %0b (result %0d)", bv, ev, checked));
  endfunction

  function int pending();
    return exp_overlap.size();
  endfunction
endclass

module tb_triangle_box_overlap_test_top;
  import tbo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  tbo_tri_if tri_in ();
  tbo_res_if res_out ();
  tbo_cfg_if cfg ();

  triangle_box_overlap_test_top dut (
    .clk(clk), .rst(rst), .tri_in(tri_in), .res_out(res_out), .cfg(cfg)
  );

  overlap_scoreboard sb = new();

  // predictor copy of the registers
  longint box_lo[3];
  longint box_hi[3];
  longint margin;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  longint cycle_count;
  int n_config;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // sign of a*b - c*d with non-negative operands up to 34 bits
  function automatic int prod_cmp(longint a, longint b, longint c, longint d);
    logic [127:0] l;
    logic [127:0] r;
    l = 128'(a) * 128'(b);
    r = 128'(c) * 128'(d);
    return (l > r) ? 1 : (l < r) ? -1 : 0;
  endfunction

  function automatic bit clip_edge(longint a[3], longint b[3]);
    longint n0, d0, n1, d1, dir, p, q, num, den;
    n0 = 0; d0 = 1; n1 = 1; d1 = 1;
    for (int ax = 0; ax < 3; ax++) begin
      dir = b[ax] - a[ax];
      for (int side = 0; side < 2; side++) begin
        p = side ? dir : -dir;
        q = side ? box_hi[ax] - a[ax] : a[ax] - box_lo[ax];
        if (p == 0) begin
          if (q < 0) return 1'b0;
        end else if (p < 0) begin
          num = -q; den = -p;
          if (num > 0) begin
            if (num > den) return 1'b0;
            if (prod_cmp(num, d0, n0, den) > 0) begin
              n0 = num; d0 = den;
            end
          end
        end else begin
          if (q < 0) return 1'b0;
          if (q < p && prod_cmp(q, d1, n1, p) < 0) begin
            n1 = q; d1 = p;
          end
        end
      end
    end
    return prod_cmp(n0, d1, n1, d0) <= 0;
  endfunction

  task automatic predict_overlap(logic [31:0] c[9], output bit ov, output bit bv);
    longint v[3][3];
    bit in_box;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = sx(c[i*3+k]);
    bv = 1'b0;
    for (int i = 0; i < 3; i++) begin
      in_box = 1'b1;
      for (int k = 0; k < 3; k++)
        if (v[i][k] < box_lo[k] - margin || v[i][k] > box_hi[k] + margin) in_box = 1'b0;
      if (in_box) bv = 1'b1;
    end
    ov = bv;
    for (int i = 0; i < 3 && !ov; i++)
      if (clip_edge(v[i], v[(i+1)%3])) ov = 1'b1;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    n_config++;
    case (idx)
      REG_BOX_LOW_X, REG_BOX_LOW_Y, REG_BOX_LOW_Z: box_lo[int'(idx)] = sx(val);
      REG_BOX_HIGH_X, REG_BOX_HIGH_Y, REG_BOX_HIGH_Z: box_hi[int'(idx) - 3] = sx(val);
      REG_VERTEX_MARGIN: margin = longint'(val[15:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  // an out-of-range index must leave every register alone
  task automatic write_bad_index();
    cfg.valid <= 1'b1;
    cfg.index <= 3'd7;
    cfg.data <= $urandom;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz, logic [15:0] m);
    write_reg(REG_BOX_LOW_X, lx);
    write_reg(REG_BOX_LOW_Y, ly);
    write_reg(REG_BOX_LOW_Z, lz);
    write_reg(REG_BOX_HIGH_X, hx);
    write_reg(REG_BOX_HIGH_Y, hy);
    write_reg(REG_BOX_HIGH_Z, hz);
    write_reg(REG_VERTEX_MARGIN, {16'd0, m});
  endtask

  // called at a falling edge; returns at a falling edge with valid still up,
  // the next call or drain() takes it down
  task automatic send_triangle(logic [31:0] c[9]);
    bit ov, bv;
    while ($urandom_range(99) < send_idle_pct) begin
      tri_in.valid <= 1'b0;
      @(negedge clk);
    end
    tri_in.valid <= 1'b1;
    {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z} <= {c[0], c[1], c[2]};
    {tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} <= {c[3], c[4], c[5]};
    {tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} <= {c[6], c[7], c[8]};
    do @(posedge clk); while (!tri_in.ready);
    predict_overlap(c, ov, bv);
    sb.note_triangle(ov, bv);
    @(negedge clk);
  endtask

  // result side: random stall, plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      res_out.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_out.valid && res_out.ready)
      sb.check_result(res_out.overlaps, res_out.hit_by_vertex);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord(int lo, int hi);
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($urandom_range(hi - lo) + lo);
    endcase
  endfunction

  // mostly near the box so that clipping decides, some wide-range noise
  task automatic random_triangle(output logic [31:0] c[9]);
    int span;
    span = 1 << $urandom_range(20, 2);
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(9) == 0) c[i] = $urandom;
      else if ($urandom_range(5) == 0 && i >= 3) c[i] = c[i-3];
      else c[i] = 32'(box_lo[i%3] - span + longint'($urandom_range(3 * span)));
      if ($urandom_range(39) == 0) c[i] = pick_coord(-4, 4);
    end
  endtask

  task automatic drain();
    tri_in.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(int count, int idle, int stall);
    logic [31:0] c[9];
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      random_triangle(c);
      send_triangle(c);
    end
  endtask

  task automatic random_box();
    int lo[3];
    int sz;
    for (int k = 0; k < 3; k++) begin
      sz = (1 << $urandom_range(18, 0));
      lo[k] = $urandom_range(1 << 22) - (1 << 21);
      if ($urandom_range(7) == 0) sz = -$urandom_range(50, 1); // inverted
      write_reg(cfg_reg_t'(k), lo[k]);
      write_reg(cfg_reg_t'(k + 3), lo[k] + sz);
    end
    write_reg(REG_VERTEX_MARGIN, $urandom_range(3) == 0 ? 32'hffff : $urandom_range(300));
  endtask

  initial begin
    logic [31:0] c[9];
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    margin = 7;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    tri_in.valid = 1'b0;
    {tri_in.v0_x, tri_in.v0_y, tri_in.v0_z} = '0;
    {tri_in.v1_x, tri_in.v1_y, tri_in.v1_z} = '0;
    {tri_in.v2_x, tri_in.v2_y, tri_in.v2_z} = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_BOX_LOW_X;
    cfg.data = '0;
    res_out.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset box: point at origin, margin 7
    c = '{default: 32'd0};
    send_triangle(c);
    c = '{32'd7, -32'sd7, 32'd7, 32'd8, 0, 0, 32'd8, 0, 0};
    send_triangle(c);
    c = '{32'd8, 0, 0, 32'd9, 0, 0, 32'd10, 0, 0};
    send_triangle(c);
    drain();

    // unit box from 0 to 1.0, zero margin
    set_box(0, 0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 16'd0);
    write_bad_index();
    // edge passing straight through, no vertex inside
    c = '{-32'sh1_0000, 32'h8000, 32'h8000, 32'h2_0000, 32'h8000, 32'h8000,
          -32'sh1_0000, 32'h8000, 32'h8000};
    send_triangle(c);
    // edge grazing a corner exactly
    c = '{-32'sh1_0000, 32'h1_0000, 32'h8000, 32'h1_0000, -32'sh1_0000, 32'h8000,
          32'h5_0000, 32'h5_0000, 32'h5_0000};
    send_triangle(c);
    // parallel to a slab and outside it
    c = '{-32'sh1_0000, 32'h2_0000, 0, 32'h2_0000, 32'h2_0000, 0,
          32'h2_0000, 32'h3_0000, 0};
    send_triangle(c);
    // miss: passes beside the box
    c = '{32'h3_0000, 0, 0, 0, 32'h3_0000, 0, 32'h3_0000, 32'h3_0000, 0};
    send_triangle(c);
    // degenerate triangle, all vertices outside
    c = '{32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000,
          32'h2_0000, 32'h2_0000, 32'h2_0000};
    send_triangle(c);
    // extremes
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_triangle(c);
    c = '{default: 32'hffff_ffff};
    send_triangle(c);
    // just outside unwidened box, then margin catches it
    c = '{32'h1_0001, 0, 0, 32'h5_0000, 0, 0, 32'h5_0000, 32'h1, 0};
    send_triangle(c);
    drain();
    write_reg(REG_VERTEX_MARGIN, 32'hffff);
    send_triangle(c);
    drain();

    // extreme box covering the whole range, then inverted
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    c = '{32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 1, 1, 1};
    send_triangle(c);
    drain();
    set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h7fff_ffff, 0, 0, 0};
    send_triangle(c);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      random_box();
      case (ph % 4)
        0: random_phase(150, 0, 0);
        1: random_phase(60, 84, 0);
        2: random_phase(80, 0, 84);
        default: random_phase(100, 7, 7);
      endcase
      if (ph == 4) begin
        // long receiver hold-off while triangles keep coming
        hold_off_cycles = 200;
        random_phase(60, 0, 0);
      end
      drain();
    end

    $display("Checked %0d results (%0d overlaps, %0d by vertex), %0d register writes.",
             sb.checked, sb.hits, sb.vertex_hits, n_config);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tbo_pkg.sv
hw/rtl/tbo_if.sv
hw/rtl/tbo_edge_clip.sv
hw/rtl/triangle_box_overlap_test_top.sv
tb/tb_triangle_box_overlap_test_top.sv
